// ===== hdl/rmge_pkg.sv =====
// ----------------------------------------------------------------------------
// Run-length glyph expander package
// Shared widths, register indexes, decode phases and the group descriptor
// that passes from the sequencer to the mask unit.
// ----------------------------------------------------------------------------
package rmge_pkg;

   localparam int COORD_BITS_DEFAULT = 16;

   localparam int CODE_BITS       = 8;
   localparam int MASK_BITS       = 16;
   localparam int COLOR_BITS      = 16;
   localparam int ALPHA_BITS      = 8;
   localparam int PEN_BITS        = COLOR_BITS + ALPHA_BITS;
   localparam int CSR_DATA_BITS   = PEN_BITS;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int HALF_BITS       = 16;
   localparam int COL_BITS        = 17;
   localparam int ROW_BITS        = 17;
   localparam int LEFT_BITS       = 7;
   localparam int REM_BITS        = 8;
   localparam int OFF_BITS        = 10;
   localparam int CLIP_BITS       = 12;
   localparam int CLIP_LOW_MAX    = 1 << OFF_BITS;
   localparam int CLIP_HIGH_MAX   = (1 << OFF_BITS) - 1;
   localparam int PIXELS_PER_CODE = 8;
   localparam int GROUP_STEP      = 2 * PIXELS_PER_CODE;
   localparam int RUN_FLAG_BIT    = 7;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_GLYPH_WIDTH = 3'd0,
      REG_SKIP_ROWS   = 3'd1,
      REG_FIRST_ROW   = 3'd2,
      REG_LAST_ROW    = 3'd3,
      REG_START_COL   = 3'd4,
      REG_CLIP_LEFT   = 3'd5,
      REG_CLIP_RIGHT  = 3'd6,
      REG_PEN         = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_REPEAT  = 2'd1,
      PH_LITERAL = 2'd2
   } phase_type;

   typedef struct packed {
      logic [CODE_BITS-1:0]        pattern;
      logic                        two;
      logic [OFF_BITS-1:0]         offset;
      logic signed [CLIP_BITS-1:0] low;
      logic signed [CLIP_BITS-1:0] high;
   } group_ctl_type;

endpackage

// ===== hdl/rmge_group_mask.sv =====
// ----------------------------------------------------------------------------
// Group mask unit
// Builds the clipped 16-pixel mask of one group from the pattern byte, the
// group offset within the run and the clip bounds relative to the run start.
// ----------------------------------------------------------------------------
module rmge_group_mask (
   input  rmge_pkg::group_ctl_type              group_ctl,
   output logic [rmge_pkg::MASK_BITS-1:0]       group_mask
);
   import rmge_pkg::*;

   for (genvar i = 0; i < MASK_BITS; i++) begin : g_bit
      logic signed [CLIP_BITS-1:0] pos;
      logic                        pix;

      assign pos = $signed(CLIP_BITS'(group_ctl.offset) + CLIP_BITS'(i));
      assign pix = (i < CODE_BITS) ? group_ctl.pattern[i % CODE_BITS]
                                   : (group_ctl.two & group_ctl.pattern[i % CODE_BITS]);
      assign group_mask[i] = pix && (pos >= group_ctl.low) && (pos <= group_ctl.high);
   end

endmodule

// ===== hdl/rle_mono_glyph_expander_top.sv =====
// ----------------------------------------------------------------------------
// Run-length monochrome glyph expander
// Decodes a run-length coded 1-bit glyph byte by byte and emits clipped
// pixel masks of up to 16 pixels with position, color and alpha.
// ----------------------------------------------------------------------------
// A header byte passes through the head and check states, or only the head
// state when the glyph width is zero. A pattern byte that draws nothing, and
// any byte that arrives after the glyph has ended, is taken in the idle
// state. A pattern byte that draws is split into 16-pixel groups (1 for a
// literal byte, up to 64 for a repeat run). One shared adder steps through
// the column base, both clip bounds, the row and then one group per cycle
// while the result side does not stall, and the input is stalled until that
// sequence ends. Each item's last result carries last_of_item; a byte that
// is fully clipped, has a zero pattern, lies in a skipped row or arrives with
// zero alpha gives no result.
module rle_mono_glyph_expander_top #(
   parameter int COORD_BITS = rmge_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [rmge_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rmge_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [rmge_pkg::CODE_BITS-1:0]        req_code_byte,
   input  logic                                  req_glyph_start,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [COORD_BITS-1:0]          rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]          rsp_pixel_y,
   output logic [rmge_pkg::MASK_BITS-1:0]        rsp_pixel_mask,
   output logic [rmge_pkg::COLOR_BITS-1:0]       rsp_color,
   output logic [rmge_pkg::ALPHA_BITS-1:0]       rsp_alpha,
   output logic                                  rsp_last_of_item
);
   import rmge_pkg::*;

   localparam int XW = ((COORD_BITS > COL_BITS + 1) ? COORD_BITS : COL_BITS + 1) + 2;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_HEAD  = 9'b000000010,
      ST_CHECK = 9'b000000100,
      ST_XBASE = 9'b000001000,
      ST_LOWER = 9'b000010000,
      ST_UPPER = 9'b000100000,
      ST_YPOS  = 9'b001000000,
      ST_GROUP = 9'b010000000,
      ST_FLUSH = 9'b100000000
   } seq_state_type;

   function automatic logic signed [XW-1:0] coord_ext(input logic [HALF_BITS-1:0] v);
      logic [2*HALF_BITS-1:0]       z;
      logic signed [COORD_BITS-1:0] c;
      z = {{HALF_BITS{1'b0}}, v};
      c = z[COORD_BITS-1:0];
      return XW'(c);
   endfunction

   seq_state_type state_ff, state_in;

   logic [CODE_BITS-1:0]  glyph_width_ff;
   logic [CODE_BITS-1:0]  skip_rows_ff;
   logic [HALF_BITS-1:0]  first_row_ff;
   logic [HALF_BITS-1:0]  last_row_ff;
   logic [HALF_BITS-1:0]  start_col_ff;
   logic [HALF_BITS-1:0]  clip_left_ff;
   logic [HALF_BITS-1:0]  clip_right_ff;
   logic [PEN_BITS-1:0]   pen_ff;

   phase_type             phase_ff, phase_in;
   logic [LEFT_BITS-1:0]  bytes_left_ff, bytes_left_in;
   logic [COL_BITS-1:0]   cur_col_ff, cur_col_in;
   logic [ROW_BITS-1:0]   cur_row_ff, cur_row_in;
   logic [CODE_BITS-1:0]  rows_skipped_ff, rows_skipped_in;
   logic                  finished_ff, finished_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in;
   logic                  hold_valid_ff, hold_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [CODE_BITS-1:0]        code_ff, code_in;
   logic [COL_BITS-1:0]         col_base_ff, col_base_in;
   logic signed [XW-1:0]        x_ff, x_in;
   logic signed [CLIP_BITS-1:0] dl_ff, dl_in;
   logic signed [CLIP_BITS-1:0] dh_ff, dh_in;
   logic [COORD_BITS-1:0]       y_ff, y_in;
   logic [OFF_BITS-1:0]         off_ff, off_in;
   logic [COORD_BITS-1:0]       hold_x_ff, hold_x_in;
   logic [MASK_BITS-1:0]        hold_mask_ff, hold_mask_in;
   logic [COORD_BITS-1:0]       out_x_ff, out_x_in;
   logic [COORD_BITS-1:0]       out_y_ff, out_y_in;
   logic [MASK_BITS-1:0]        out_mask_ff, out_mask_in;
   logic [COLOR_BITS-1:0]       out_color_ff, out_color_in;
   logic [ALPHA_BITS-1:0]       out_alpha_ff, out_alpha_in;
   logic                        out_last_ff, out_last_in;

   logic signed [XW-1:0]        op_a, op_b, sum;
   logic                        op_sub;
   logic signed [CLIP_BITS-1:0] lo_clamp, hi_clamp;
   group_ctl_type               group_ctl;
   logic [MASK_BITS-1:0]        group_mask;
   logic                        out_free;
   logic                        draw;
   logic [REM_BITS-1:0]         count;
   logic [REM_BITS-1:0]         rem_next;

   always_comb begin
      op_a   = x_ff;
      op_b   = XW'(GROUP_STEP);
      op_sub = 1'b0;
      unique case (state_ff)
         ST_XBASE: begin
            op_a = coord_ext(start_col_ff);
            op_b = XW'(col_base_ff);
         end
         ST_LOWER: begin
            op_a   = coord_ext(clip_left_ff);
            op_b   = x_ff;
            op_sub = 1'b1;
         end
         ST_UPPER: begin
            op_a   = coord_ext(clip_right_ff);
            op_b   = x_ff;
            op_sub = 1'b1;
         end
         ST_YPOS, ST_CHECK: begin
            op_a = coord_ext(first_row_ff);
            op_b = XW'(cur_row_ff);
         end
         default: begin
            op_a = x_ff;
         end
      endcase
      sum = op_sub ? (op_a - op_b) : (op_a + op_b);
   end

   always_comb begin
      if (sum <= 0) begin
         lo_clamp = '0;
      end else if (sum > CLIP_LOW_MAX) begin
         lo_clamp = CLIP_BITS'(CLIP_LOW_MAX);
      end else begin
         lo_clamp = sum[CLIP_BITS-1:0];
      end
      if (sum < 0) begin
         hi_clamp = '1;
      end else if (sum > CLIP_HIGH_MAX) begin
         hi_clamp = CLIP_BITS'(CLIP_HIGH_MAX);
      end else begin
         hi_clamp = sum[CLIP_BITS-1:0];
      end
   end

   assign group_ctl.pattern = code_ff;
   assign group_ctl.two     = (rem_ff >= REM_BITS'(2));
   assign group_ctl.offset  = off_ff;
   assign group_ctl.low     = dl_ff;
   assign group_ctl.high    = dh_ff;

   rmge_group_mask u_group_mask (
      .group_ctl  (group_ctl),
      .group_mask (group_mask)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign draw     = (rows_skipped_ff >= skip_rows_ff)
                     && (pen_ff[PEN_BITS-1:COLOR_BITS] != '0)
                     && (req_code_byte != '0);
   assign count    = REM_BITS'(bytes_left_ff) + REM_BITS'(1);
   assign rem_next = group_ctl.two ? (rem_ff - REM_BITS'(2)) : (rem_ff - REM_BITS'(1));

   always_comb begin
      state_in        = state_ff;
      phase_in        = phase_ff;
      bytes_left_in   = bytes_left_ff;
      cur_col_in      = cur_col_ff;
      cur_row_in      = cur_row_ff;
      rows_skipped_in = rows_skipped_ff;
      finished_in     = finished_ff;
      rem_in          = rem_ff;
      hold_valid_in   = hold_valid_ff;
      rsp_valid_in    = rsp_valid_ff;
      code_in         = code_ff;
      col_base_in     = col_base_ff;
      x_in            = x_ff;
      dl_in           = dl_ff;
      dh_in           = dh_ff;
      y_in            = y_ff;
      off_in          = off_ff;
      hold_x_in       = hold_x_ff;
      hold_mask_in    = hold_mask_ff;
      out_x_in        = out_x_ff;
      out_y_in        = out_y_ff;
      out_mask_in     = out_mask_ff;
      out_color_in    = out_color_ff;
      out_alpha_in    = out_alpha_ff;
      out_last_in     = out_last_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               code_in     = req_code_byte;
               col_base_in = cur_col_ff;
               off_in      = '0;
               if (req_glyph_start) begin
                  phase_in        = PH_HEADER;
                  bytes_left_in   = '0;
                  cur_col_in      = '0;
                  cur_row_in      = '0;
                  rows_skipped_in = '0;
                  finished_in     = 1'b0;
                  state_in        = ST_HEAD;
               end else if (finished_ff) begin
                  state_in = ST_IDLE;
               end else if (phase_ff == PH_HEADER) begin
                  state_in = ST_HEAD;
               end else if (phase_ff == PH_REPEAT) begin
                  rem_in        = count;
                  cur_col_in    = cur_col_ff + COL_BITS'({count, 3'b000});
                  bytes_left_in = '0;
                  phase_in      = PH_HEADER;
                  if (draw) begin
                     state_in = ST_XBASE;
                  end
               end else begin
                  rem_in     = REM_BITS'(1);
                  cur_col_in = cur_col_ff + COL_BITS'(PIXELS_PER_CODE);
                  if (bytes_left_ff == '0) begin
                     phase_in = PH_HEADER;
                  end else begin
                     bytes_left_in = bytes_left_ff - LEFT_BITS'(1);
                  end
                  if (draw) begin
                     state_in = ST_XBASE;
                  end
               end
            end
         end
         ST_HEAD: begin
            if (glyph_width_ff == '0) begin
               finished_in = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               if (cur_col_ff >= COL_BITS'(glyph_width_ff)) begin
                  cur_col_in = '0;
                  if (rows_skipped_ff < skip_rows_ff) begin
                     rows_skipped_in = rows_skipped_ff + CODE_BITS'(1);
                  end else begin
                     cur_row_in = cur_row_ff + ROW_BITS'(1);
                  end
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((rows_skipped_ff >= skip_rows_ff) && (sum > coord_ext(last_row_ff))) begin
               finished_in = 1'b1;
            end else begin
               bytes_left_in = code_ff[LEFT_BITS-1:0];
               phase_in      = code_ff[RUN_FLAG_BIT] ? PH_REPEAT : PH_LITERAL;
            end
            state_in = ST_IDLE;
         end
         ST_XBASE: begin
            x_in     = sum;
            state_in = ST_LOWER;
         end
         ST_LOWER: begin
            dl_in    = lo_clamp;
            state_in = ST_UPPER;
         end
         ST_UPPER: begin
            dh_in    = hi_clamp;
            state_in = ST_YPOS;
         end
         ST_YPOS: begin
            y_in     = sum[COORD_BITS-1:0];
            state_in = ST_GROUP;
         end
         ST_GROUP: begin
            if ((group_mask != '0) && hold_valid_ff && !out_free) begin
               state_in = ST_GROUP;
            end else begin
               if (group_mask != '0) begin
                  if (hold_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     out_x_in     = hold_x_ff;
                     out_y_in     = y_ff;
                     out_mask_in  = hold_mask_ff;
                     out_color_in = pen_ff[COLOR_BITS-1:0];
                     out_alpha_in = pen_ff[PEN_BITS-1:COLOR_BITS];
                     out_last_in  = 1'b0;
                  end
                  hold_valid_in = 1'b1;
                  hold_x_in     = x_ff[COORD_BITS-1:0];
                  hold_mask_in  = group_mask;
               end
               x_in   = sum;
               off_in = off_ff + OFF_BITS'(GROUP_STEP);
               rem_in = rem_next;
               if (rem_next == '0) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_x_in      = hold_x_ff;
               out_y_in      = y_ff;
               out_mask_in   = hold_mask_ff;
               out_color_in  = pen_ff[COLOR_BITS-1:0];
               out_alpha_in  = pen_ff[PEN_BITS-1:COLOR_BITS];
               out_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         glyph_width_ff  <= '0;
         skip_rows_ff    <= '0;
         first_row_ff    <= '0;
         last_row_ff     <= '0;
         start_col_ff    <= '0;
         clip_left_ff    <= '0;
         clip_right_ff   <= '0;
         pen_ff          <= '0;
         phase_ff        <= PH_HEADER;
         bytes_left_ff   <= '0;
         cur_col_ff      <= '0;
         cur_row_ff      <= '0;
         rows_skipped_ff <= '0;
         finished_ff     <= 1'b0;
         rem_ff          <= '0;
         hold_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         phase_ff        <= phase_in;
         bytes_left_ff   <= bytes_left_in;
         cur_col_ff      <= cur_col_in;
         cur_row_ff      <= cur_row_in;
         rows_skipped_ff <= rows_skipped_in;
         finished_ff     <= finished_in;
         rem_ff          <= rem_in;
         hold_valid_ff   <= hold_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_GLYPH_WIDTH: glyph_width_ff <= csr_write_data[CODE_BITS-1:0];
               REG_SKIP_ROWS:   skip_rows_ff   <= csr_write_data[CODE_BITS-1:0];
               REG_FIRST_ROW:   first_row_ff   <= csr_write_data[HALF_BITS-1:0];
               REG_LAST_ROW:    last_row_ff    <= csr_write_data[HALF_BITS-1:0];
               REG_START_COL:   start_col_ff   <= csr_write_data[HALF_BITS-1:0];
               REG_CLIP_LEFT:   clip_left_ff   <= csr_write_data[HALF_BITS-1:0];
               REG_CLIP_RIGHT:  clip_right_ff  <= csr_write_data[HALF_BITS-1:0];
               REG_PEN:         pen_ff         <= csr_write_data[PEN_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      code_ff      <= code_in;
      col_base_ff  <= col_base_in;
      x_ff         <= x_in;
      dl_ff        <= dl_in;
      dh_ff        <= dh_in;
      y_ff         <= y_in;
      off_ff       <= off_in;
      hold_x_ff    <= hold_x_in;
      hold_mask_ff <= hold_mask_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_mask_ff  <= out_mask_in;
      out_color_ff <= out_color_in;
      out_alpha_ff <= out_alpha_in;
      out_last_ff  <= out_last_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_x      = out_x_ff;
   assign rsp_pixel_y      = out_y_ff;
   assign rsp_pixel_mask   = out_mask_ff;
   assign rsp_color        = out_color_ff;
   assign rsp_alpha        = out_alpha_ff;
   assign rsp_last_of_item = out_last_ff;

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the run-length monochrome glyph expander
// Drives coded glyph bytes through the valid/stall input port under several
// register settings and predicts every pixel group the block must emit. Each
// group is checked field by field against the oldest expected group.
// ----------------------------------------------------------------------------
module tb_top;

   import rmge_pkg::*;

   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 6;
   localparam int SETTLE_CYCLES   = 160;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int MAX_REPORTS     = 10;
   localparam int RANDOM_ITEMS    = 100;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        mask;
      logic [15:0]        color;
      logic [7:0]         alpha;
      logic               last;
   } pixel_group_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [CSR_DATA_BITS-1:0]    csr_write_data = '0;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [CODE_BITS-1:0]        req_code_byte = '0;
   logic                        req_glyph_start = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [15:0]          rsp_pixel_x;
   logic signed [15:0]          rsp_pixel_y;
   logic [MASK_BITS-1:0]        rsp_pixel_mask;
   logic [COLOR_BITS-1:0]       rsp_color;
   logic [ALPHA_BITS-1:0]       rsp_alpha;
   logic                        rsp_last_of_item;

   // Register copies used for prediction.
   logic [7:0]         width_cfg = '0;
   logic [7:0]         skip_cfg = '0;
   logic signed [15:0] first_row_cfg = '0;
   logic signed [15:0] last_row_cfg = '0;
   logic signed [15:0] start_col_cfg = '0;
   logic signed [15:0] clip_left_cfg = '0;
   logic signed [15:0] clip_right_cfg = '0;
   logic [23:0]        pen_cfg = '0;

   // Decoder state used for prediction.
   phase_type   dec_phase = PH_HEADER;
   logic [7:0]  run_left = '0;
   logic [16:0] col_pos = '0;
   int unsigned row_pos = 0;
   logic [7:0]  rows_passed = '0;
   logic        glyph_done = 1'b0;

   pixel_group_type pending_groups[$];
   int unsigned     codes_decoded = 0;
   int unsigned     mismatches = 0;
   int unsigned     cycle_count = 0;
   bit              sender_idles = 1'b1;
   bit              receiver_idles = 1'b1;

   rle_mono_glyph_expander_top #(
      .COORD_BITS(COORD_BITS_DEFAULT)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_code_byte    (req_code_byte),
      .req_glyph_start  (req_glyph_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_mask   (rsp_pixel_mask),
      .rsp_color        (rsp_color),
      .rsp_alpha        (rsp_alpha),
      .rsp_last_of_item (rsp_last_of_item)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int add_group(input logic [15:0] bits, input int nbits,
                                    input longint rel_col);
      longint          x0;
      longint          xi;
      longint          y;
      logic [15:0]     mask;
      pixel_group_type grp;
      int              i;
      x0 = longint'(start_col_cfg) + rel_col;
      mask = '0;
      for (i = 0; i < nbits; i++) begin
         xi = x0 + i;
         if (bits[i] && xi >= longint'(clip_left_cfg) && xi <= longint'(clip_right_cfg))
            mask[i] = 1'b1;
      end
      if (mask == '0)
         return 0;
      y = longint'(first_row_cfg) + longint'(row_pos);
      grp.x = x0[15:0];
      grp.y = y[15:0];
      grp.mask = mask;
      grp.color = pen_cfg[15:0];
      grp.alpha = pen_cfg[23:16];
      grp.last = 1'b0;
      pending_groups.push_back(grp);
      return 1;
   endfunction

   function automatic void expand_code(input logic [7:0] code, input logic start);
      logic            draw;
      int unsigned     count;
      int unsigned     k;
      int              produced;
      pixel_group_type tail;
      produced = 0;
      codes_decoded++;
      if (start) begin
         dec_phase = PH_HEADER;
         run_left = '0;
         col_pos = '0;
         row_pos = 0;
         rows_passed = '0;
         glyph_done = 1'b0;
      end
      if (glyph_done)
         return;
      draw = (rows_passed >= skip_cfg) && (pen_cfg[23:16] != 8'd0);
      case (dec_phase)
         PH_HEADER: begin
            if (width_cfg == 8'd0) begin
               glyph_done = 1'b1;
            end else begin
               if (col_pos >= width_cfg) begin
                  col_pos = '0;
                  if (rows_passed < skip_cfg)
                     rows_passed++;
                  else
                     row_pos++;
               end
               if (rows_passed >= skip_cfg &&
                   longint'(first_row_cfg) + longint'(row_pos) > longint'(last_row_cfg))
                  glyph_done = 1'b1;
            end
            if (!glyph_done) begin
               run_left = {1'b0, code[6:0]};
               dec_phase = code[7] ? PH_REPEAT : PH_LITERAL;
            end
         end
         PH_REPEAT: begin
            count = run_left + 1;
            if (draw && code != 8'd0) begin
               for (k = 0; k < count; k += 2) begin
                  if (count - k >= 2)
                     produced += add_group({code, code}, 16, longint'(col_pos) + 8 * k);
                  else
                     produced += add_group({8'h00, code}, 8, longint'(col_pos) + 8 * k);
               end
            end
            col_pos = col_pos + 17'(8 * count);
            run_left = '0;
            dec_phase = PH_HEADER;
         end
         PH_LITERAL: begin
            if (draw && code != 8'd0)
               produced += add_group({8'h00, code}, 8, longint'(col_pos));
            col_pos = col_pos + 17'd8;
            if (run_left == 8'd0)
               dec_phase = PH_HEADER;
            else
               run_left--;
         end
         default: dec_phase = PH_HEADER;
      endcase
      if (produced > 0) begin
         tail = pending_groups.pop_back();
         tail.last = 1'b1;
         pending_groups.push_back(tail);
      end
   endfunction

   function automatic void report_group(input string what, input pixel_group_type got,
                                        input pixel_group_type want);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%s at cycle %0d: got x=%0d y=%0d mask=%h color=%h alpha=%h last=%b, %s",
                  what, cycle_count, got.x, got.y, got.mask, got.color, got.alpha, got.last,
                  $sformatf("expected x=%0d y=%0d mask=%h color=%h alpha=%h last=%b",
                            want.x, want.y, want.mask, want.color, want.alpha, want.last));
   endfunction

   function automatic logic [7:0] rand_pattern();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= receiver_idles && ($urandom_range(99) < 8);
   end

   always @(posedge clock) begin : check_groups
      pixel_group_type got;
      pixel_group_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_pixel_x, rsp_pixel_y, rsp_pixel_mask, rsp_color, rsp_alpha,
                rsp_last_of_item};
         if (pending_groups.size() == 0) begin
            report_group("unexpected group", got, '0);
         end else begin
            want = pending_groups.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.mask !== want.mask ||
                got.color !== want.color || got.alpha !== want.alpha ||
                got.last !== want.last)
               report_group("group mismatch", got, want);
         end
      end
   end

   task automatic send_code(input logic [7:0] code, input logic start);
      int gap;
      if (sender_idles && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 2);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_code_byte <= code;
      req_glyph_start <= start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expand_code(code, start);
   endtask

   task automatic wait_drained(input int hold);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_groups.size() != 0);
      repeat (hold) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [23:0] value,
                                 input int bits);
      logic [23:0] keep;
      logic [23:0] data;
      keep = (bits >= 24) ? 24'hFFFFFF : ((24'd1 << bits) - 24'd1);
      data = 24'($urandom_range(24'hFFFFFF));
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= (data & ~keep) | (value & keep);
      @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] width, input logic [7:0] skip,
                            input logic signed [15:0] row_top,
                            input logic signed [15:0] row_bottom,
                            input logic signed [15:0] col_base,
                            input logic signed [15:0] clip_lo,
                            input logic signed [15:0] clip_hi,
                            input logic [23:0] pen_value);
      write_register(REG_GLYPH_WIDTH, 24'(width), 8);
      write_register(REG_SKIP_ROWS, 24'(skip), 8);
      write_register(REG_FIRST_ROW, 24'(row_top), 16);
      write_register(REG_LAST_ROW, 24'(row_bottom), 16);
      write_register(REG_START_COL, 24'(col_base), 16);
      write_register(REG_CLIP_LEFT, 24'(clip_lo), 16);
      write_register(REG_CLIP_RIGHT, 24'(clip_hi), 16);
      write_register(REG_PEN, pen_value, 24);
      csr_write_enable <= 1'b0;
      width_cfg = width;
      skip_cfg = skip;
      first_row_cfg = row_top;
      last_row_cfg = row_bottom;
      start_col_cfg = col_base;
      clip_left_cfg = clip_lo;
      clip_right_cfg = clip_hi;
      pen_cfg = pen_value;
   endtask

   // Sends a well-formed glyph of random runs, with optional stray bytes.
   task automatic send_glyph(input int rows, input int noise_pct);
      int unsigned col;
      int unsigned run;
      int unsigned k;
      int          r;
      logic        opening;
      opening = 1'b1;
      for (r = 0; r < rows; r++) begin
         col = 0;
         do begin
            run = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(3);
            if ($urandom_range(1) == 1) begin
               send_code(8'h80 | run[7:0], opening);
               send_code(rand_pattern(), 1'b0);
            end else begin
               run = run % 16;
               send_code(run[7:0], opening);
               for (k = 0; k <= run; k++)
                  send_code(rand_pattern(), 1'b0);
            end
            opening = 1'b0;
            col += 8 * (run + 1);
            if ($urandom_range(99) < noise_pct)
               send_code(8'($urandom_range(255)), $urandom_range(9) == 0);
         end while (col < width_cfg);
      end
      send_code(8'($urandom_range(255)), opening);
      repeat ($urandom_range(2)) send_code(8'($urandom_range(255)), 1'b0);
   endtask

   task automatic test_directed_runs();
      configure(8'd16, 8'd0, 16'sd5, 16'sd6, 16'sd100, 16'h8000, 16'h7FFF, 24'hFF_ABCD);
      send_code(8'h01, 1'b1);
      send_code(8'hFF, 1'b0);
      send_code(8'h00, 1'b0);
      send_code(8'h80, 1'b0);
      send_code(8'h81, 1'b0);
      send_code(8'hFF, 1'b0);
      send_code(8'h55, 1'b0);
      send_code(8'h82, 1'b0);
      send_code(8'h7F, 1'b0);
      send_code(8'h82, 1'b1);
      send_code(8'h3C, 1'b0);
      send_code(8'h00, 1'b0);
      send_code(8'h80, 1'b0);
   endtask

   task automatic test_special_cases();
      // Zero alpha decodes but draws nothing.
      wait_drained(SETTLE_CYCLES);
      configure(8'd16, 8'd0, 16'sd0, 16'sd4, 16'sd0, 16'h8000, 16'h7FFF, 24'h00_FFFF);
      send_code(8'h80, 1'b1);
      send_code(8'hFF, 1'b0);
      send_code(8'h80, 1'b0);
      send_code(8'hFF, 1'b0);
      // Zero width ends the glyph on the first header.
      wait_drained(SETTLE_CYCLES);
      configure(8'd0, 8'd0, 16'sd0, 16'sd4, 16'sd0, 16'h8000, 16'h7FFF, 24'hFF_0001);
      send_code(8'h80, 1'b1);
      send_code(8'hFF, 1'b0);
      // Skipped row followed by an empty visible range.
      wait_drained(SETTLE_CYCLES);
      configure(8'd8, 8'd1, 16'sd3, 16'sd2, 16'sd0, 16'h8000, 16'h7FFF, 24'hFF_0001);
      send_code(8'h80, 1'b1);
      send_code(8'h0F, 1'b0);
      send_code(8'h80, 1'b0);
      send_code(8'hF0, 1'b0);
      // Partial and full clipping near the top of the coordinate range.
      wait_drained(SETTLE_CYCLES);
      configure(8'd32, 8'd0, 16'h8000, 16'h8000, 16'h7FF8, 16'h7FFD, 16'h7FFF, 24'h01_FFFF);
      send_code(8'h81, 1'b1);
      send_code(8'hFF, 1'b0);
      send_code(8'h00, 1'b0);
      send_code(8'hFF, 1'b0);
   endtask

   task automatic test_sender_pause();
      wait_drained(SETTLE_CYCLES);
      configure(8'd24, 8'd0, 16'sd0, 16'sd3, 16'sd0, 16'h8000, 16'h7FFF, 24'h80_0F0F);
      send_code(8'hFF, 1'b1);
      send_code(8'hA5, 1'b0);
      wait_drained(0);
      send_code(8'h02, 1'b0);
      send_code(8'h01, 1'b0);
      wait_drained(0);
      send_code(8'h80, 1'b0);
      send_code(8'hFF, 1'b0);
      send_code(8'h80, 1'b0);
      send_code(8'h3C, 1'b0);
   endtask

   task automatic test_back_to_back();
      wait_drained(SETTLE_CYCLES);
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      configure(8'd32, 8'd1, -16'sd5, -16'sd2, -16'sd10, -16'sd4, 16'sd40, 24'hFF_1234);
      send_glyph(5, 0);
      send_glyph(4, 0);
      wait_drained(SETTLE_CYCLES);
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
   endtask

   task automatic test_random_glyphs();
      int unsigned        items_base;
      logic [7:0]         width;
      logic [7:0]         skip;
      logic signed [15:0] row_top;
      logic signed [15:0] row_bottom;
      logic signed [15:0] col_base;
      logic signed [15:0] clip_lo;
      logic signed [15:0] clip_hi;
      logic [7:0]         alpha;
      items_base = codes_decoded;
      while ((codes_decoded - items_base) < RANDOM_ITEMS) begin
         wait_drained(SETTLE_CYCLES);
         case ($urandom_range(9))
            0: width = 8'd0;
            1: width = 8'd255;
            2: width = 8'd1;
            default: width = 8'($urandom_range(8, 48));
         endcase
         skip = ($urandom_range(14) == 0) ? 8'd255 : 8'($urandom_range(2));
         case ($urandom_range(7))
            0: row_top = 16'h7FFF;
            1: row_top = 16'h8000;
            default: row_top = 16'($urandom_range(400) - 200);
         endcase
         case ($urandom_range(7))
            0: row_bottom = row_top - 16'sd1;
            1: row_bottom = 16'h7FFF;
            default: row_bottom = 16'(row_top + $urandom_range(4));
         endcase
         case ($urandom_range(7))
            0: col_base = 16'h7FF8;
            1: col_base = 16'h8000;
            default: col_base = 16'($urandom_range(600) - 300);
         endcase
         case ($urandom_range(5))
            0, 1: begin
               clip_lo = 16'h8000;
               clip_hi = 16'h7FFF;
            end
            2, 3: begin
               clip_lo = 16'(col_base + $urandom_range(40) - 8);
               clip_hi = 16'(clip_lo + $urandom_range(48));
            end
            4: begin
               clip_lo = 16'($urandom_range(65535));
               clip_hi = 16'($urandom_range(65535));
            end
            default: begin
               clip_lo = 16'(col_base + $urandom_range(20));
               clip_hi = 16'(clip_lo - 1 - $urandom_range(5));
            end
         endcase
         case ($urandom_range(9))
            0: alpha = 8'h00;
            1: alpha = 8'hFF;
            default: alpha = 8'($urandom_range(1, 255));
         endcase
         configure(width, skip, row_top, row_bottom, col_base, clip_lo, clip_hi,
                   {alpha, 16'($urandom_range(65535))});
         repeat ($urandom_range(1, 3)) send_glyph($urandom_range(1, 4), 5);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_runs();
      test_special_cases();
      test_sender_pause();
      test_back_to_back();
      test_random_glyphs();
      wait_drained(SETTLE_CYCLES);
      if (mismatches == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/rmge_pkg.sv
hdl/rmge_group_mask.sv
hdl/rle_mono_glyph_expander_top.sv
test/tb_top.sv
